// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the UTF-8 stream decoder.
// No dependencies; files that assert take this header with an include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: condition does not hold");
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/u8d_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies; imported by the decode stage, the result queue and the top level.
`timescale 1ns / 1ps

package u8d_pkg;

  typedef enum logic [1:0] {
    KIND_CP      = 2'd0,
    KIND_INVALID = 2'd1,
    KIND_TRUNC   = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  localparam logic [7:0]  CONT_MASK    = 8'hC0;
  localparam logic [7:0]  CONT_TAG     = 8'h80;
  localparam logic [7:0]  BAD_LEAD     = 8'hFE;
  localparam logic [7:0]  PAYLOAD_MASK = 8'h3F;
  localparam logic [30:0] ASCII_MAX    = 31'h7F;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    kind_t       kind;
    logic [30:0] code_point;
    logic [2:0]  seq_len;
    logic        last;
  } result_t;

  // Up to two results leave the decode stage per byte; slot 1 only with slot 0.
  typedef struct packed {
    logic [1:0]         valid;
    result_t [1:0]      slot;
  } push_t;

endpackage

// File: hdl/u8d_decode.sv
// Decode stage: input byte register, sequence state and the result logic.
// Depends on u8d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8d_decode
  import u8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [7:0] byte_in,
  output logic       busy,
  output push_t      push
);

  typedef struct packed {
    logic        has_res;
    result_t     res;
    logic [2:0]  len;
    logic [2:0]  pend;
    logic [30:0] init;
  } first_t;

  logic        valid_q;
  logic [7:0]  byte_q;
  logic [2:0]  pending;
  logic [2:0]  seqlen;
  logic [30:0] partial;
  logic [2:0]  pending_next;
  logic [2:0]  seqlen_next;
  logic [30:0] partial_next;
  logic        is_cont;
  logic [30:0] cont_value;
  first_t      fb;

  function automatic first_t first_byte(input logic [7:0] b);
    first_t f;
    logic [2:0] n;
    f.has_res         = 1'b1;
    f.res.kind        = KIND_CP;
    f.res.code_point  = '0;
    f.res.seq_len     = 3'd1;
    f.res.last        = 1'b1;
    f.len             = 3'd0;
    f.pend            = 3'd0;
    f.init            = '0;
    n                 = 3'd6;
    if (b == 8'd0) begin
      f.res.kind = KIND_END;
    end else if (!b[7]) begin
      f.res.code_point = {23'd0, b};
    end else if ((b & CONT_MASK) == CONT_TAG || (b & BAD_LEAD) == BAD_LEAD) begin
      f.res.kind = KIND_INVALID;
    end else begin
      // A lead byte opens a sequence and reports nothing yet.
      if (b[7:5] == 3'b110) begin
        n = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        n = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        n = 3'd4;
      end else if (b[7:2] == 6'b111110) begin
        n = 3'd5;
      end
      f.has_res = 1'b0;
      f.len     = n;
      f.pend    = n - 3'd1;
      f.init    = {23'd0, b & (8'hFF >> n)};
    end
    return f;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      pending <= '0;
      seqlen  <= '0;
      partial <= '0;
    end else begin
      valid_q <= load;
      pending <= pending_next;
      seqlen  <= seqlen_next;
      partial <= partial_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_q <= byte_in;
    end
  end

  assign busy       = valid_q;
  assign is_cont    = (byte_q & CONT_MASK) == CONT_TAG;
  assign cont_value = {partial[24:0], byte_q[5:0] & PAYLOAD_MASK[5:0]};
  assign fb         = first_byte(byte_q);

  always_comb begin
    pending_next = pending;
    seqlen_next  = seqlen;
    partial_next = partial;
    push         = '0;
    if (valid_q) begin
      if (pending != 3'd0 && is_cont) begin
        pending_next = pending - 3'd1;
        partial_next = cont_value;
        if (pending == 3'd1) begin
          push.valid[0]              = 1'b1;
          push.slot[0].kind          = (cont_value > ASCII_MAX) ? KIND_CP : KIND_INVALID;
          push.slot[0].code_point    = (cont_value > ASCII_MAX) ? cont_value : '0;
          push.slot[0].seq_len       = seqlen;
          push.slot[0].last          = 1'b1;
          seqlen_next                = '0;
          partial_next               = '0;
        end
      end else if (pending != 3'd0) begin
        // Broken sequence: report the bytes taken, then treat this byte afresh.
        push.valid[0]           = 1'b1;
        push.slot[0].kind       = (byte_q == 8'd0) ? KIND_TRUNC : KIND_INVALID;
        push.slot[0].code_point = '0;
        push.slot[0].seq_len    = seqlen - pending;
        push.slot[0].last       = !fb.has_res;
        push.valid[1]           = fb.has_res;
        push.slot[1]            = fb.res;
        pending_next            = fb.pend;
        seqlen_next             = fb.len;
        partial_next            = fb.init;
      end else begin
        push.valid[0] = fb.has_res;
        push.slot[0]  = fb.res;
        pending_next  = fb.pend;
        seqlen_next   = fb.len;
        partial_next  = fb.init;
      end
    end
  end

  `ASSERT_IMPL(a_slot1_needs_slot0, clk, rst, push.valid[1], push.valid[0])
  `ASSERT_ALWAYS(a_pending_range, clk, rst, pending <= 3'd5)
  `ASSERT_IMPL(a_len_covers_pending, clk, rst, pending != 3'd0, seqlen > pending)

endmodule

// File: hdl/u8d_fifo.sv
// Result queue: takes up to two results per cycle and hands out one.
// Depends on u8d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8d_fifo
  import u8d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  input  logic               pop,
  output logic               not_empty,
  output result_t            head,
  output logic [FIFO_CW-1:0] level
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic [FIFO_CW-1:0]   count_next;
  logic [FIFO_AW-1:0]   wr_ptr_next;
  logic [FIFO_CW-1:0]   push_n;

  assign push_n      = FIFO_CW'(push.valid[0]) + FIFO_CW'(push.valid[1]);
  assign count_next  = count + push_n - FIFO_CW'(pop);
  assign wr_ptr_next = wr_ptr + FIFO_AW'(push_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid[0]) begin
      mem[wr_ptr] <= push.slot[0];
    end
    if (push.valid[1]) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.slot[1];
    end
  end

  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];
  assign level     = count;

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, count <= FIFO_CW'(FIFO_DEPTH))
  `ASSERT_IMPL(a_room_for_pair, clk, rst, push.valid[1], count <= FIFO_CW'(FIFO_DEPTH - 2))
  `ASSERT_NEXT(a_pop_drains, clk, rst, pop && push_n == '0, count == $past(count) - FIFO_CW'(1))

endmodule

// File: hdl/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder: decode stage and result queue.
// Depends on u8d_pkg, u8d_decode and u8d_fifo.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    byte_in[7:0]
//   output   out_valid / out_ready  kind[1:0], code_point[30:0], seq_len[2:0], last
//
// One byte is taken per clock while in_ready is high; its results pass through the decode stage's
// byte register and then the result queue. A byte that breaks a sequence and is not itself a lead
// byte yields two results, which leave the queue one after the other. in_ready falls when the
// eight-entry result queue could not hold the worst case of the byte in decode and the next one.
// in_ready depends on the queue level and on whether a byte is in decode, never on out_ready.
// Reset clears the sequence state and empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module utf8_stream_decoder_top
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [30:0] code_point,
  output logic [2:0]  seq_len,
  output logic        last
);

  logic               load;
  logic               busy;
  push_t              push;
  result_t            head;
  logic [FIFO_CW-1:0] level;
  logic [FIFO_CW:0]   need;

  // Reserve two entries for the byte in decode and two for the incoming one.
  assign need     = {1'b0, level} + (busy ? (FIFO_CW + 1)'(4) : (FIFO_CW + 1)'(2));
  assign in_ready = need <= (FIFO_CW + 1)'(FIFO_DEPTH);
  assign load     = in_valid && in_ready;

  u8d_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .byte_in (byte_in),
    .busy    (busy),
    .push    (push)
  );

  u8d_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_valid && out_ready),
    .not_empty (out_valid),
    .head      (head),
    .level     (level)
  );

  assign kind       = head.kind;
  assign code_point = head.code_point;
  assign seq_len    = head.seq_len;
  assign last       = head.last;

endmodule

// File: bench/utf8_checker.sv
// Checker for the UTF-8 stream decoder: watches both channels, predicts the results of
// every accepted byte and compares them in order. Depends on u8d_pkg only.
`timescale 1ns / 1ps

module utf8_checker
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic [30:0] code_point,
  input  logic [2:0]  seq_len,
  input  logic        last,
  output int          fail_count,
  output int          open_results
);

  // Decoder state as the predictor sees it.
  logic [2:0]  cont_left;
  logic [2:0]  seq_total;
  logic [30:0] gathered;

  result_t decoded_q[$];
  result_t want;
  bit      bad;

  initial begin
    fail_count   = 0;
    open_results = 0;
    cont_left    = '0;
    seq_total    = '0;
    gathered     = '0;
  end

  function automatic result_t make_result(kind_t k, logic [30:0] cp, logic [2:0] len);
    result_t r;
    r.kind       = k;
    r.code_point = (k == KIND_CP) ? cp : '0;
    r.seq_len    = len;
    r.last       = 1'b0;
    return r;
  endfunction

  // A byte seen with no sequence open: either reports at once or opens a sequence.
  function automatic bit take_first(input logic [7:0] b, output result_t r);
    logic [2:0] n;
    r = '0;
    if (b == 8'h00) begin
      r = make_result(KIND_END, '0, 3'd1);
      return 1'b1;
    end
    if (!b[7]) begin
      r = make_result(KIND_CP, {23'd0, b}, 3'd1);
      return 1'b1;
    end
    if ((b & CONT_MASK) == CONT_TAG || (b & BAD_LEAD) == BAD_LEAD) begin
      r = make_result(KIND_INVALID, '0, 3'd1);
      return 1'b1;
    end
    if (b[7:5] == 3'b110) n = 3'd2;
    else if (b[7:4] == 4'b1110) n = 3'd3;
    else if (b[7:3] == 5'b11110) n = 3'd4;
    else if (b[7:2] == 6'b111110) n = 3'd5;
    else n = 3'd6;
    seq_total = n;
    cont_left = n - 3'd1;
    gathered  = {23'd0, b & (8'hFF >> n)};
    return 1'b0;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    result_t r [2];
    result_t tmp;
    int      n;
    n = 0;
    if (cont_left != 3'd0) begin
      if ((b & CONT_MASK) == CONT_TAG) begin
        gathered  = {gathered[24:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 3'd0) begin
          r[0] = make_result(gathered <= ASCII_MAX ? KIND_INVALID : KIND_CP, gathered,
                             seq_total);
          n = 1;
          seq_total = '0;
          gathered  = '0;
        end
      end else begin
        // A broken sequence is reported, then the same byte starts afresh.
        r[0] = make_result(b == 8'h00 ? KIND_TRUNC : KIND_INVALID, '0, seq_total - cont_left);
        n = 1;
        cont_left = '0;
        seq_total = '0;
        gathered  = '0;
        if (take_first(b, tmp)) begin
          r[1] = tmp;
          n = 2;
        end
      end
    end else if (take_first(b, tmp)) begin
      r[0] = tmp;
      n = 1;
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) decoded_q.push_back(r[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cont_left = '0;
      seq_total = '0;
      gathered  = '0;
      decoded_q.delete();
    end else begin
      if (in_valid && in_ready) predict_byte(byte_in);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with none expected: kind %0d, code point %h, length %0d, last %b",
                   $time, kind, code_point, seq_len, last);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          bad  = 1'b0;
          if (kind !== want.kind) begin
            $display("%0t: kind expected %0d, actual %0d", $time, want.kind, kind);
            bad = 1'b1;
          end
          if (code_point !== want.code_point) begin
            $display("%0t: code point expected %h, actual %h", $time, want.code_point,
                     code_point);
            bad = 1'b1;
          end
          if (seq_len !== want.seq_len) begin
            $display("%0t: length expected %0d, actual %0d", $time, want.seq_len, seq_len);
            bad = 1'b1;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %b, actual %b", $time, want.last, last);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
    end
    open_results = decoded_q.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus and receiver.
// Depends on utf8_stream_decoder_top and on utf8_checker, which does all the checking.
`timescale 1ns / 1ps

module testbench;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_in;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [30:0] code_point;
  logic [2:0]  seq_len;
  logic        last;
  int          fail_count;
  int          open_results;

  int          bytes_sent;
  int          rx_cycles;

  utf8_stream_decoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .code_point (code_point),
    .seq_len    (seq_len),
    .last       (last)
  );

  utf8_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_in      (byte_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .code_point   (code_point),
    .seq_len      (seq_len),
    .last         (last),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offers one byte and returns at the edge where the transaction completes.
  // Idling is switched off for a stretch in the middle of the random part.
  task automatic send_byte(input logic [7:0] b);
    if ((bytes_sent < 300 || bytes_sent > 450) && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] lead_byte(input int len);
    return ~(8'hFF >> len) | (8'($urandom) & (8'hFF >> (len + 1)));
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic send_sequence();
    int         len;
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 70) begin
      len = $urandom_range(1, 6);
      if (len == 1) begin
        send_byte(8'($urandom_range(0, 127)));
      end else begin
        send_byte(lead_byte(len));
        repeat (len - 1) send_byte(cont_byte());
      end
    end else if (pick < 85) begin
      // Sequence cut short by a byte that is not a continuation, now and then a zero.
      len = $urandom_range(2, 6);
      send_byte(lead_byte(len));
      repeat ($urandom_range(0, len - 2)) send_byte(cont_byte());
      if ($urandom_range(3) == 0) begin
        b = 8'h00;
      end else begin
        b = 8'($urandom);
        while (b[7:6] == 2'b10) b = 8'($urandom);
      end
      send_byte(b);
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] directed_bytes [$];
    directed_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFE, 8'hFF,
                       8'hC3, 8'hA9,
                       8'hE2, 8'h82, 8'hAC,
                       8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                       8'hC1, 8'hBF,
                       8'hE2, 8'h82, 8'h00,
                       8'hC3, 8'hC3, 8'hA9,
                       8'hF0, 8'h9F, 8'h41};
    bytes_sent = 0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    byte_in  <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    while (bytes_sent < 700) send_sequence();
    // A closing zero flushes any sequence still open.
    send_byte(8'h00);
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && open_results == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off that backs the queue up into the
  // input, then a stretch that takes every result.
  initial begin
    rx_cycles = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles >= 400 && rx_cycles < 480) begin
        out_ready <= 1'b0;
      end else if (rx_cycles >= 600 && rx_cycles < 900) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 28);
      end
    end
  end

  initial begin
    #200000;
    $display("testbench failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/u8d_pkg.sv
hdl/u8d_decode.sv
hdl/u8d_fifo.sv
hdl/utf8_stream_decoder_top.sv
bench/utf8_checker.sv
bench/testbench.sv
